// ===== hw/rtl/segp_pkg.sv =====
`default_nettype none
package segp_pkg;

    localparam int TILE_DEPTH = 65536;
    localparam int BASE_DEPTH = 32768;
    localparam int TILE_AW    = $clog2(TILE_DEPTH);
    localparam int BASE_AW    = $clog2(BASE_DEPTH);
    // Tile length and base length counters must hold the depth itself.
    localparam int TLW        = TILE_AW + 1;
    localparam int BLW        = BASE_AW + 1;
    // Odd base value 2*i+3 for an index below BASE_DEPTH.
    localparam int VW         = BLW + 1;
    localparam int DIV_NW     = 38;
    localparam int DIV_DW     = VW;

    typedef enum logic [4:0] {
        ST_TCLR,
        ST_IDLE,
        ST_CHK,
        ST_SQ1W,
        ST_DV1W,
        ST_MUL,
        ST_DVLO,
        ST_DVHI,
        ST_SQ2W,
        ST_BCLR,
        ST_BSQ,
        ST_BCHK,
        ST_BMRK,
        ST_TSET,
        ST_PRD,
        ST_PCHK,
        ST_PDIV,
        ST_PMRK,
        ST_CNT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/segmented_odd_prime_sieve.sv =====
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_upper_limit, s_part_index, s_part_count
// m_        out        m_valid / m_ready  m_odd_prime_count, m_too_many_parts
//
// One item at a time: s_ready is high only while the block is idle.
// An item runs a setup (two 16-step roots, three 38-step divisions), then clears
// the base store over base_len entries and runs the base sieve writes, then per tile
// one marking write per multiple, a division for each base prime whose square lies
// below the tile, and a count over the tile; single-port writes into the bit stores
// make these steps run one after another.
// After reset the whole tile store is swept clear before s_ready goes high.
// A result held on m_valid stalls the block until it is taken.
module segmented_odd_prime_sieve (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_upper_limit,
    input  wire logic [5:0]  s_part_index,
    input  wire logic [6:0]  s_part_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [30:0] m_odd_prime_count,
    output logic             m_too_many_parts
);

    localparam int TLW     = segp_pkg::TLW;
    localparam int BLW     = segp_pkg::BLW;
    localparam int VW      = segp_pkg::VW;
    localparam int TILE_AW = segp_pkg::TILE_AW;
    localparam int BASE_AW = segp_pkg::BASE_AW;
    localparam int NW      = segp_pkg::DIV_NW;
    localparam int DW      = segp_pkg::DIV_DW;

    segp_pkg::state_t state_reg, state_next;

    logic [31:0]    n_reg, n_next;
    logic [5:0]     part_reg, part_next;
    logic [6:0]     parts_reg, parts_next;
    logic [30:0]    oddn_reg, oddn_next;
    logic [15:0]    root_reg, root_next;
    logic [BLW-1:0] blen_reg, blen_next;
    logic [30:0]    lo_reg, lo_next;
    logic [30:0]    hi_reg, hi_next;
    logic [30:0]    ts_reg, ts_next;
    logic [BLW-1:0] i_reg, i_next;
    logic [VW-1:0]  j_reg, j_next;
    logic [33:0]    vv_reg, vv_next;
    logic [32:0]    low_reg, low_next;
    logic [33:0]    high_reg, high_next;
    logic [TLW-1:0] tlen_reg, tlen_next;
    logic [TLW:0]   idx_reg, idx_next;
    logic [TLW-1:0] k_reg, k_next;
    logic           pend_reg, pend_next;
    logic [TILE_AW-1:0] paddr_reg, paddr_next;
    logic [31:0]    cnt_reg, cnt_next;
    logic           err_reg, err_next;
    logic [TLW-1:0] clr_reg, clr_next;

    logic [VW-1:0]  v;
    logic [33:0]    v_sq;
    logic [30:0]    size;
    logic [30:0]    rest;
    logic [15:0]    blen_raw;
    logic [37:0]    prod_lo, prod_hi;
    logic [VW:0]    add0, add1;

    logic           div_start, div_done;
    logic [NW-1:0]  div_num, div_q;
    logic [DW-1:0]  div_den, div_r;
    logic           sq_start, sq_done;
    logic [31:0]    sq_x;
    logic [15:0]    sq_root;

    logic               base_we, base_wdata, base_rdata;
    logic [BASE_AW-1:0] base_waddr, base_raddr;
    logic               tile_we, tile_wdata, tile_rdata;
    logic [TILE_AW-1:0] tile_waddr, tile_raddr;

    assign v        = VW'({i_reg, 1'b0}) + VW'(3);
    assign v_sq     = 34'(v) * 34'(v);
    assign size     = hi_reg - lo_reg;
    assign rest     = size - ts_reg;
    assign blen_raw = (sq_root >= 16'd3) ? ((sq_root - 16'd1) >> 1) : 16'd0;
    assign prod_lo  = 38'(part_reg) * 38'(oddn_reg);
    assign prod_hi  = (38'(part_reg) + 38'd1) * 38'(oddn_reg);
    assign add0     = (div_r == '0) ? '0 : ((VW+1)'(v) - (VW+1)'(div_r));
    assign add1     = add0[0] ? (add0 + (VW+1)'(v)) : add0;

    segp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q),
        .rem     (div_r)
    );

    segp_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .x       (sq_x),
        .done    (sq_done),
        .root    (sq_root)
    );

    segp_ram #(.WIDTH(1), .DEPTH(segp_pkg::BASE_DEPTH)) u_base_ram (
        .aclk  (aclk),
        .we    (base_we),
        .waddr (base_waddr),
        .wdata (base_wdata),
        .raddr (base_raddr),
        .rdata (base_rdata)
    );

    segp_ram #(.WIDTH(1), .DEPTH(segp_pkg::TILE_DEPTH)) u_tile_ram (
        .aclk  (aclk),
        .we    (tile_we),
        .waddr (tile_waddr),
        .wdata (tile_wdata),
        .raddr (tile_raddr),
        .rdata (tile_rdata)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            segp_pkg::ST_TCLR: begin
                if (clr_reg == TLW'(segp_pkg::TILE_DEPTH - 1)) state_next = segp_pkg::ST_IDLE;
            end
            segp_pkg::ST_IDLE: begin
                if (s_valid) state_next = segp_pkg::ST_CHK;
            end
            segp_pkg::ST_CHK: begin
                if (n_reg < 32'd3 || parts_reg == '0) state_next = segp_pkg::ST_DONE;
                else state_next = segp_pkg::ST_SQ1W;
            end
            segp_pkg::ST_SQ1W: begin
                if (sq_done) state_next = segp_pkg::ST_DV1W;
            end
            segp_pkg::ST_DV1W: begin
                if (div_done) begin
                    if (div_q < NW'(root_reg) || 7'(part_reg) >= parts_reg) begin
                        state_next = segp_pkg::ST_DONE;
                    end else begin
                        state_next = segp_pkg::ST_MUL;
                    end
                end
            end
            segp_pkg::ST_MUL: state_next = segp_pkg::ST_DVLO;
            segp_pkg::ST_DVLO: begin
                if (div_done) state_next = segp_pkg::ST_DVHI;
            end
            segp_pkg::ST_DVHI: begin
                if (div_done) state_next = segp_pkg::ST_SQ2W;
            end
            segp_pkg::ST_SQ2W: begin
                if (sq_done) state_next = segp_pkg::ST_BCLR;
            end
            segp_pkg::ST_BCLR: begin
                if (i_reg >= blen_reg) state_next = segp_pkg::ST_BSQ;
            end
            segp_pkg::ST_BSQ: begin
                if (i_reg >= blen_reg) state_next = segp_pkg::ST_TSET;
                else state_next = segp_pkg::ST_BCHK;
            end
            segp_pkg::ST_BCHK: begin
                if (vv_reg > 34'(root_reg)) state_next = segp_pkg::ST_TSET;
                else if (base_rdata) state_next = segp_pkg::ST_BSQ;
                else state_next = segp_pkg::ST_BMRK;
            end
            segp_pkg::ST_BMRK: begin
                if (j_reg >= VW'(blen_reg)) state_next = segp_pkg::ST_BSQ;
            end
            segp_pkg::ST_TSET: begin
                if (ts_reg >= size) state_next = segp_pkg::ST_DONE;
                else state_next = segp_pkg::ST_PRD;
            end
            segp_pkg::ST_PRD: begin
                if (i_reg >= blen_reg) state_next = segp_pkg::ST_CNT;
                else state_next = segp_pkg::ST_PCHK;
            end
            segp_pkg::ST_PCHK: begin
                if (base_rdata) state_next = segp_pkg::ST_PRD;
                else if (vv_reg > high_reg) state_next = segp_pkg::ST_CNT;
                else if (vv_reg >= 34'(low_reg)) state_next = segp_pkg::ST_PMRK;
                else state_next = segp_pkg::ST_PDIV;
            end
            segp_pkg::ST_PDIV: begin
                if (div_done) state_next = segp_pkg::ST_PMRK;
            end
            segp_pkg::ST_PMRK: begin
                if (idx_reg >= (TLW+1)'(tlen_reg)) state_next = segp_pkg::ST_PRD;
            end
            segp_pkg::ST_CNT: begin
                if (k_reg >= tlen_reg && !pend_reg) state_next = segp_pkg::ST_TSET;
            end
            segp_pkg::ST_DONE: begin
                if (m_ready) state_next = segp_pkg::ST_IDLE;
            end
            default: state_next = segp_pkg::ST_IDLE;
        endcase
    end

    // Datapath, unit starts and memory ports.
    always_comb begin
        n_next     = n_reg;
        part_next  = part_reg;
        parts_next = parts_reg;
        oddn_next  = oddn_reg;
        root_next  = root_reg;
        blen_next  = blen_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        ts_next    = ts_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        vv_next    = vv_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        tlen_next  = tlen_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        pend_next  = 1'b0;
        paddr_next = paddr_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        clr_next   = clr_reg;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        sq_start   = 1'b0;
        sq_x       = '0;
        base_we    = 1'b0;
        base_waddr = i_reg[BASE_AW-1:0];
        base_wdata = 1'b0;
        base_raddr = i_reg[BASE_AW-1:0];
        tile_we    = 1'b0;
        tile_waddr = clr_reg[TILE_AW-1:0];
        tile_wdata = 1'b0;
        tile_raddr = k_reg[TILE_AW-1:0];
        case (state_reg)
            segp_pkg::ST_TCLR: begin
                tile_we  = 1'b1;
                clr_next = clr_reg + 1'b1;
            end
            segp_pkg::ST_IDLE: begin
                n_next     = s_upper_limit;
                part_next  = s_part_index;
                parts_next = s_part_count;
            end
            segp_pkg::ST_CHK: begin
                cnt_next  = '0;
                ts_next   = '0;
                oddn_next = 31'((n_reg - 32'd1) >> 1);
                err_next  = (n_reg >= 32'd3) && (parts_reg == '0);
                if (n_reg >= 32'd3 && parts_reg != '0) begin
                    sq_start = 1'b1;
                    sq_x     = 32'((n_reg - 32'd1) >> 1);
                end
            end
            segp_pkg::ST_SQ1W: begin
                if (sq_done) begin
                    root_next = sq_root;
                    div_start = 1'b1;
                    div_num   = NW'(oddn_reg) - NW'(1);
                    div_den   = DW'(parts_reg);
                end
            end
            segp_pkg::ST_DV1W: begin
                if (div_done) err_next = div_q < NW'(root_reg);
            end
            segp_pkg::ST_MUL: begin
                div_start = 1'b1;
                div_num   = prod_lo;
                div_den   = DW'(parts_reg);
            end
            segp_pkg::ST_DVLO: begin
                if (div_done) begin
                    lo_next   = div_q[30:0];
                    div_start = 1'b1;
                    div_num   = prod_hi;
                    div_den   = DW'(parts_reg);
                end
            end
            segp_pkg::ST_DVHI: begin
                if (div_done) begin
                    hi_next  = div_q[30:0];
                    sq_start = 1'b1;
                    sq_x     = n_reg;
                end
            end
            segp_pkg::ST_SQ2W: begin
                // The base length is taken from the root as it arrives.
                if (sq_done) begin
                    root_next = sq_root;
                    i_next    = '0;
                    if (32'(blen_raw) > 32'(segp_pkg::BASE_DEPTH)) begin
                        blen_next = BLW'(segp_pkg::BASE_DEPTH);
                    end else begin
                        blen_next = BLW'(blen_raw);
                    end
                end
            end
            segp_pkg::ST_BCLR: begin
                if (i_reg < blen_reg) begin
                    base_we = 1'b1;
                    i_next  = i_reg + 1'b1;
                end else begin
                    i_next = '0;
                end
            end
            segp_pkg::ST_BSQ: begin
                vv_next = v_sq;
            end
            segp_pkg::ST_BCHK: begin
                if (vv_reg <= 34'(root_reg)) begin
                    if (base_rdata) i_next = i_reg + 1'b1;
                    else j_next = VW'((vv_reg - 34'd3) >> 1);
                end
            end
            segp_pkg::ST_BMRK: begin
                if (j_reg < VW'(blen_reg)) begin
                    base_we    = 1'b1;
                    base_waddr = j_reg[BASE_AW-1:0];
                    base_wdata = 1'b1;
                    j_next     = j_reg + v;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            segp_pkg::ST_TSET: begin
                if (32'(rest) > 32'(segp_pkg::TILE_DEPTH)) begin
                    tlen_next = TLW'(segp_pkg::TILE_DEPTH);
                end else begin
                    tlen_next = TLW'(rest);
                end
                low_next  = {1'b0, lo_reg + ts_reg, 1'b0} + 33'd3;
                high_next = 34'({1'b0, lo_reg + ts_reg, 1'b0}) + 34'd3
                          + 34'({tlen_next - 1'b1, 1'b0});
                i_next    = '0;
            end
            segp_pkg::ST_PRD: begin
                vv_next = v_sq;
                k_next  = '0;
            end
            segp_pkg::ST_PCHK: begin
                if (base_rdata) begin
                    i_next = i_reg + 1'b1;
                end else if (vv_reg <= high_reg && vv_reg >= 34'(low_reg)) begin
                    idx_next = (TLW+1)'((vv_reg - 34'(low_reg)) >> 1);
                end else if (vv_reg <= high_reg) begin
                    div_start = 1'b1;
                    div_num   = NW'(low_reg);
                    div_den   = DW'(v);
                end
            end
            segp_pkg::ST_PDIV: begin
                // Offset to the first odd multiple at or above the tile's low value.
                if (div_done) idx_next = (TLW+1)'(add1 >> 1);
            end
            segp_pkg::ST_PMRK: begin
                tile_waddr = idx_reg[TILE_AW-1:0];
                tile_wdata = 1'b1;
                if (idx_reg < (TLW+1)'(tlen_reg)) begin
                    tile_we  = 1'b1;
                    idx_next = idx_reg + (TLW+1)'(v);
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            segp_pkg::ST_CNT: begin
                // Each bit is read, counted in the following cycle and cleared for the next tile.
                if (k_reg < tlen_reg) begin
                    k_next     = k_reg + 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = k_reg[TILE_AW-1:0];
                end
                if (pend_reg) begin
                    tile_we    = 1'b1;
                    tile_waddr = paddr_reg;
                    if (!tile_rdata) cnt_next = cnt_reg + 32'd1;
                end
                if (k_reg >= tlen_reg && !pend_reg) begin
                    ts_next = ts_reg + 31'(tlen_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= segp_pkg::ST_TCLR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
        end
        n_reg     <= n_next;
        part_reg  <= part_next;
        parts_reg <= parts_next;
        oddn_reg  <= oddn_next;
        root_reg  <= root_next;
        blen_reg  <= blen_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        ts_reg    <= ts_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        vv_reg    <= vv_next;
        low_reg   <= low_next;
        high_reg  <= high_next;
        tlen_reg  <= tlen_next;
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        paddr_reg <= paddr_next;
        cnt_reg   <= cnt_next;
        err_reg   <= err_next;
    end

    assign s_ready           = (state_reg == segp_pkg::ST_IDLE);
    assign m_valid           = (state_reg == segp_pkg::ST_DONE);
    assign m_odd_prime_count = err_reg ? 31'd0 : cnt_reg[30:0];
    assign m_too_many_parts  = err_reg;

`ifndef SYNTH
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while a result waits");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_too_many_parts) |-> (m_odd_prime_count == '0))
        else $error("error result carries a count");
    a_cnt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == segp_pkg::ST_CNT && pend_reg) |-> (tile_we && !tile_wdata))
        else $error("counted tile bit not cleared");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/segp_ram.sv =====
`default_nettype none
module segp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/segp_div.sv =====
`default_nettype none
module segp_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [segp_pkg::DIV_NW-1:0]  num,
    input  wire logic [segp_pkg::DIV_DW-1:0]  den,
    output logic                              done,
    output logic      [segp_pkg::DIV_NW-1:0]  quot,
    output logic      [segp_pkg::DIV_DW-1:0]  rem
);

    localparam int NW = segp_pkg::DIV_NW;
    localparam int DW = segp_pkg::DIV_DW;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   r_sh;
    logic [DW:0]   r_sub;

    // Restoring division, one quotient bit a cycle, numerator shifted out of q_reg.
    always_comb begin
        r_sh      = {r_reg[DW-1:0], q_reg[NW-1]};
        r_sub     = r_sh - {1'b0, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (r_sh >= {1'b0, d_reg}) begin
                r_next = r_sub;
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = r_sh;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg[DW-1:0];

`ifndef SYNTH
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider started while busy");
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (r_reg < {1'b0, d_reg})) else $error("remainder not below divisor");
    a_done_once: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("done held longer than a cycle");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/segp_sqrt.sv =====
`default_nettype none
module segp_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] x,
    output logic             done,
    output logic      [15:0] root
);

    logic [31:0] x_reg, x_next;
    logic [15:0] r_reg, r_next;
    logic [15:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [15:0] t;
    logic [31:0] t_sq;

    // One result bit a cycle, from the top bit down, tested by squaring.
    assign t    = r_reg | bit_reg;
    assign t_sq = t * t;

    always_comb begin
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = x;
            r_next    = '0;
            bit_next  = 16'h8000;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (t_sq <= x_reg) begin
                r_next = t;
            end
            bit_next = bit_reg >> 1;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("root unit started while busy");
    a_root_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> ((r_reg * r_reg) <= x_reg)) else $error("root too large");
    a_done_once: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("done held longer than a cycle");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_segmented_odd_prime_sieve.sv =====
`timescale 1ns / 1ps

module tb_segmented_odd_prime_sieve;

    localparam int  TILE_LEN    = 65536;
    localparam int  BASE_LEN    = 32768;
    localparam int  IDLE_PCT    = 29;
    localparam int  N_RANDOM    = 100;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic [31:0] upper_limit;
        logic [5:0]  part_index;
        logic [6:0]  part_count;
    } request_t;

    typedef struct packed {
        logic [30:0] odd_prime_count;
        logic        too_many_parts;
    } count_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_upper_limit = '0;
    logic [5:0]  s_part_index = '0;
    logic [6:0]  s_part_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [30:0] m_odd_prime_count;
    logic        m_too_many_parts;

    request_t pending_requests[$];
    count_t   expected_counts[$];
    bit       request_taken = 1'b0;
    int       requests_sent = 0;
    int       error_count = 0;
    longint   cycle_count = 0;
    bit       tile_marked[TILE_LEN];
    bit       base_marked[BASE_LEN];

    segmented_odd_prime_sieve u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_upper_limit     (s_upper_limit),
        .s_part_index      (s_part_index),
        .s_part_count      (s_part_count),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_odd_prime_count (m_odd_prime_count),
        .m_too_many_parts  (m_too_many_parts)
    );

    always #4 aclk = ~aclk;

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        longint unsigned t;
        r = 0;
        b = 64'd1 << 16;
        while (b != 0) begin
            t = r | b;
            if (t * t <= x) r = t;
            b >>= 1;
        end
        return r;
    endfunction

    function automatic count_t count_share_primes(input request_t req);
        count_t res;
        longint unsigned n, part, parts, odd_n, lo_idx, size, root, base_len;
        longint unsigned tile_pos, t_len, low_val, high_val, q, q2, first, j, total;
        res = '0;
        n = req.upper_limit;
        part = req.part_index;
        parts = req.part_count;
        if (n < 3) return res;
        if (parts == 0) begin
            res.too_many_parts = 1'b1;
            return res;
        end
        odd_n = (n - 1) / 2;
        if ((odd_n - 1) / parts < floor_root(odd_n)) begin
            res.too_many_parts = 1'b1;
            return res;
        end
        if (part >= parts) return res;
        lo_idx = part * odd_n / parts;
        size = (part + 1) * odd_n / parts - lo_idx;
        root = floor_root(n);
        base_len = (root >= 3) ? (root - 1) / 2 : 0;
        if (base_len > BASE_LEN) base_len = BASE_LEN;
        for (int i = 0; i < BASE_LEN; i++) base_marked[i] = 1'b0;
        for (longint unsigned i = 0; i < base_len; i++) begin
            q = 2 * i + 3;
            if (q * q > root) break;
            if (!base_marked[i]) begin
                for (j = (q * q - 3) / 2; j < base_len; j += q) base_marked[j] = 1'b1;
            end
        end
        total = 0;
        tile_pos = 0;
        while (tile_pos < size) begin
            t_len = size - tile_pos;
            if (t_len > TILE_LEN) t_len = TILE_LEN;
            low_val = 2 * (lo_idx + tile_pos) + 3;
            high_val = low_val + 2 * (t_len - 1);
            for (int k = 0; k < TILE_LEN; k++) tile_marked[k] = 1'b0;
            for (longint unsigned b = 0; b < base_len; b++) begin
                if (!base_marked[b]) begin
                    q = 2 * b + 3;
                    q2 = q * q;
                    if (q2 > high_val) break;
                    if (q2 >= low_val) begin
                        first = q2;
                    end else begin
                        first = ((low_val + q - 1) / q) * q;
                        if (first[0] == 1'b0) first += q;
                    end
                    for (j = (first - low_val) / 2; j < t_len; j += q) tile_marked[j] = 1'b1;
                end
            end
            for (longint unsigned k = 0; k < t_len; k++)
                if (!tile_marked[k]) total++;
            tile_pos += t_len;
        end
        res.odd_prime_count = total[30:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic add_request(input logic [31:0] n, input logic [5:0] idx,
                               input logic [6:0] cnt);
        request_t r;
        r.upper_limit = n;
        r.part_index = idx;
        r.part_count = cnt;
        pending_requests.push_back(r);
    endtask

    // The middle of the run has no idling on either side.
    function automatic bit idle_now();
        if (requests_sent >= 50 && requests_sent < 75) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        request_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_counts.push_back(count_share_primes({s_upper_limit, s_part_index,
                                                          s_part_count}));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                count_t want;
                want = expected_counts.pop_front();
                if (m_odd_prime_count !== want.odd_prime_count)
                    report_mismatch($sformatf("odd_prime_count %0d, expected %0d",
                                              m_odd_prime_count, want.odd_prime_count));
                if (m_too_many_parts !== want.too_many_parts)
                    report_mismatch($sformatf("too_many_parts %0b, expected %0b",
                                              m_too_many_parts, want.too_many_parts));
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("segmented_odd_prime_sieve test failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_now();
            if (!s_valid || request_taken) begin
                if (pending_requests.size() != 0 && !idle_now()) begin
                    request_t r;
                    r = pending_requests.pop_front();
                    s_upper_limit <= r.upper_limit;
                    s_part_index <= r.part_index;
                    s_part_count <= r.part_count;
                    s_valid <= 1'b1;
                    requests_sent <= requests_sent + 1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        int kind;
        int cnt;
        // Limits below three, then the smallest real cases.
        add_request(32'd0, 6'd0, 7'd1);
        add_request(32'd2, 6'd0, 7'd1);
        add_request(32'd3, 6'd0, 7'd1);
        add_request(32'd9, 6'd0, 7'd1);
        add_request(32'd25, 6'd0, 7'd1);
        add_request(32'd1000, 6'd3, 7'd4);
        // Zero part count, and shares too small for the base primes.
        add_request(32'hFFFF_FFFF, 6'd0, 7'd0);
        add_request(32'd100, 6'd0, 7'd64);
        add_request(32'd30000, 6'd63, 7'd127);
        // Part counts of 64 and above and the top share index.
        add_request(32'd100000, 6'd63, 7'd127);
        add_request(32'd50000, 6'd63, 7'd64);
        // Large limits with an empty share stay cheap.
        add_request(32'hFFFF_FFFF, 6'd63, 7'd5);
        add_request(32'h8000_0000, 6'd7, 7'd3);
        // One request spans more than one tile.
        add_request(32'd140001, 6'd0, 7'd1);
        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                cnt = $urandom_range(1, 8);
                add_request(32'($urandom_range(3, 6000)), 6'($urandom_range(0, cnt - 1)),
                            7'(cnt));
            end else if (kind < 85) begin
                cnt = $urandom_range(1, 63);
                add_request(32'($urandom), 6'($urandom_range(cnt, 63)), 7'(cnt));
            end else begin
                add_request(32'($urandom_range(0, 3000)), 6'($urandom), 7'($urandom));
            end
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_requests.size() == 0 && !s_valid);
        wait (expected_counts.size() == 0);
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("segmented_odd_prime_sieve test passed");
        end else begin
            $display("segmented_odd_prime_sieve test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/segp_pkg.sv
hw/rtl/segp_ram.sv
hw/rtl/segp_div.sv
hw/rtl/segp_sqrt.sv
hw/rtl/segmented_odd_prime_sieve.sv
tb/sv/tb_segmented_odd_prime_sieve.sv
